[rtl/sprite_post_clip_macros.svh]
`ifndef SPRITE_POST_CLIP_MACROS_SVH
`define SPRITE_POST_CLIP_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sprc_pkg.sv]
`timescale 1ns / 1ps

package sprc_pkg;

    localparam logic [31:0] FRAC_ONE  = 32'h0001_0000;
    localparam logic [31:0] FRAC_MASK = 32'h0000_FFFF;
    localparam logic [31:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG   = 32'h8000_0000;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DIV_BITS            = 32;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_BITS / DIV_STEPS_PER_STAGE;

    // frac, yl, yh, len
    localparam int DIV1_SIDE_W = 32 + 32 + 32 + 8;
    // frac, yl, yh, trim
    localparam int DIV2_SIDE_W = 32 + 32 + 32 + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPRITE_SCALE  = 3'd0,
        CFG_SPRITE_TOP    = 3'd1,
        CFG_INVERSE_SCALE = 3'd2,
        CFG_TEXTURE_MID   = 3'd3,
        CFG_CENTER_Y      = 3'd4,
        CFG_VIEW_HEIGHT   = 3'd5
    } cfg_index_t;

    function automatic logic [31:0] asr16(input logic [31:0] v);
        return {{16{v[31]}}, v[31:16]};
    endfunction

endpackage

[rtl/sprc_div.sv]
`timescale 1ns / 1ps

module sprc_div #(
    parameter int SIDE_W = sprc_pkg::DIV1_SIDE_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       dividend,
    input  logic [31:0]       divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       quotient,
    output logic [SIDE_W-1:0] out_side
);
    import sprc_pkg::*;

    localparam int NS = DIV_STAGES;

    logic [NS:0]       v_reg;
    logic [NS:0]       neg_reg;
    logic [NS:0]       sat_reg;
    logic [31:0]       r_reg    [0:NS];
    logic [31:0]       sh_reg   [0:NS];
    logic [31:0]       q_reg    [0:NS];
    logic [31:0]       d_reg    [0:NS];
    logic [SIDE_W-1:0] side_reg [0:NS];

    logic [31:0] mag_a;
    logic [31:0] mag_b;

    logic              out_valid_reg;
    logic [31:0]       quotient_reg;
    logic [SIDE_W-1:0] out_side_reg;

    assign mag_a = dividend[31] ? (32'd0 - dividend) : dividend;
    assign mag_b = divisor[31]  ? (32'd0 - divisor)  : divisor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= {16'd0, mag_a[31:16]};
            sh_reg[0]   <= {mag_a[15:0], 16'd0};
            q_reg[0]    <= '0;
            d_reg[0]    <= mag_b;
            neg_reg[0]  <= dividend[31] ^ divisor[31];
            sat_reg[0]  <= (mag_a >> 14) >= mag_b;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [31:0] r_next;
        logic [31:0] sh_next;
        logic [31:0] q_next;

        always_comb begin
            logic [32:0] r2;
            logic [33:0] diff;
            r_next  = r_reg[k-1];
            sh_next = sh_reg[k-1];
            q_next  = q_reg[k-1];
            for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
                r2   = {r_next, sh_next[31]};
                diff = {1'b0, r2} - {2'b00, d_reg[k-1]};
                if (!diff[33]) begin
                    r_next = diff[31:0];
                    q_next = {q_next[30:0], 1'b1};
                end else begin
                    r_next = r2[31:0];
                    q_next = {q_next[30:0], 1'b0};
                end
                sh_next = {sh_next[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]    <= r_next;
                sh_reg[k]   <= sh_next;
                q_reg[k]    <= q_next;
                d_reg[k]    <= d_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sat_reg[NS]) begin
                quotient_reg <= neg_reg[NS] ? SAT_NEG : SAT_POS;
            end else begin
                quotient_reg <= neg_reg[NS] ? (32'd0 - q_reg[NS]) : q_reg[NS];
            end
            out_side_reg <= side_reg[NS];
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;
    assign out_side  = out_side_reg;

endmodule

[rtl/sprite_post_clip.sv]
`timescale 1ns / 1ps

// Channel  Direction  Payload
// s_       in         tdata: post_start, post_length, ceiling_row, floor_row
// m_       out        tdata: top_row, bottom_row, texture_frac, draw_enable
// cfg_     in         index + data, one register write per transfer
//
// One post per cycle while the pipeline is not stalled; two 18-stage dividers run in series.
// The whole pipeline advances when the output register is empty or taken.
// A stall freezes every stage; nothing is lost or repeated.
// aresetn is synchronous; it clears valid bits and loads register defaults.

module sprite_post_clip (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] post_start, [15:8] post_length, [29:16] ceiling_row,
    // [42:30] floor_row, [47:43] zero
    input  logic [sprc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] top_row, [31:16] bottom_row, [63:32] texture_frac,
    // [64] draw_enable, [71:65] zero
    output logic [sprc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sprc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sprc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sprc_pkg::*;

    logic [30:0] sprite_scale_reg;
    logic [31:0] sprite_top_reg;
    logic [31:0] inverse_scale_reg;
    logic [31:0] texture_mid_reg;
    logic [31:0] center_y_reg;
    logic [12:0] view_height_reg;

    logic adv;
    logic [31:0] is_w;

    assign cfg_ready = 1'b1;
    assign is_w      = inverse_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sprite_scale_reg  <= 31'd65536;
            sprite_top_reg    <= 32'd0;
            inverse_scale_reg <= 32'd65535;
            texture_mid_reg   <= 32'd0;
            center_y_reg      <= 32'd6553600;
            view_height_reg   <= 13'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPRITE_SCALE:  sprite_scale_reg  <= cfg_data[30:0];
                CFG_SPRITE_TOP:    sprite_top_reg    <= cfg_data;
                CFG_INVERSE_SCALE: inverse_scale_reg <= cfg_data;
                CFG_TEXTURE_MID:   texture_mid_reg   <= cfg_data;
                CFG_CENTER_Y:      center_y_reg      <= cfg_data;
                CFG_VIEW_HEIGHT:   view_height_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: scale products, center offset
    logic        v1_reg;
    logic [7:0]  start1_reg, len1_reg;
    logic [13:0] ceil1_reg;
    logic [12:0] floor1_reg;
    logic [31:0] pst1_reg, plen1_reg, cm1_reg;

    // stage 2: projected rows, clip limits, center product
    logic        v2_reg;
    logic [7:0]  start2_reg, len2_reg;
    logic [31:0] yl2_reg, yh2_reg, toplim2_reg, botlim2_reg;
    logic [63:0] fxp2_reg;
    logic [31:0] top2_w;
    logic signed [63:0] cm_ext, is_ext;

    // stage 3: clamp, base
    logic        v3_reg;
    logic [7:0]  len3_reg;
    logic [31:0] yl3_reg, yh3_reg, base3_reg;

    // stage 4: yl * is
    logic        v4_reg;
    logic [7:0]  len4_reg;
    logic [31:0] yl4_reg, yh4_reg, base4_reg, ylis4_reg;

    // stage 5: frac
    logic        v5_reg;
    logic [7:0]  len5_reg;
    logic [31:0] yl5_reg, yh5_reg, frac5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign top2_w = sprite_top_reg + pst1_reg + 32'd1;
    assign cm_ext = $signed({{32{cm1_reg[31]}}, cm1_reg});
    assign is_ext = $signed({{32{is_w[31]}}, is_w});

    always_ff @(posedge aclk) begin
        if (adv) begin
            start1_reg <= s_tdata[7:0];
            len1_reg   <= s_tdata[15:8];
            ceil1_reg  <= s_tdata[29:16];
            floor1_reg <= s_tdata[42:30];
            pst1_reg   <= 32'({1'b0, sprite_scale_reg} * {24'd0, s_tdata[7:0]});
            plen1_reg  <= 32'({1'b0, sprite_scale_reg} * {24'd0, s_tdata[15:8]});
            cm1_reg    <= center_y_reg - FRAC_ONE;

            start2_reg  <= start1_reg;
            len2_reg    <= len1_reg;
            yl2_reg     <= asr16(top2_w + FRAC_ONE);
            yh2_reg     <= asr16(top2_w + plen1_reg);
            toplim2_reg <= {{18{ceil1_reg[13]}}, ceil1_reg} + 32'd1;
            botlim2_reg <= {19'd0, floor1_reg} - 32'd1;
            fxp2_reg    <= 64'(cm_ext * is_ext);

            len3_reg  <= len2_reg;
            yl3_reg   <= ($signed(yl2_reg) < $signed(toplim2_reg)) ? toplim2_reg : yl2_reg;
            yh3_reg   <= ($signed(botlim2_reg) < $signed(yh2_reg)) ? botlim2_reg : yh2_reg;
            base3_reg <= texture_mid_reg - {8'd0, start2_reg, 16'd0} - fxp2_reg[47:16];

            len4_reg  <= len3_reg;
            yl4_reg   <= yl3_reg;
            yh4_reg   <= yh3_reg;
            base4_reg <= base3_reg;
            ylis4_reg <= 32'(yl3_reg * is_w);

            len5_reg  <= len4_reg;
            yl5_reg   <= yl4_reg;
            yh5_reg   <= yh4_reg;
            frac5_reg <= base4_reg + ylis4_reg;
        end
    end

    // top correction division
    logic                   d1_valid;
    logic [31:0]            d1_q;
    logic [DIV1_SIDE_W-1:0] d1_side;

    sprc_div #(
        .SIDE_W (DIV1_SIDE_W)
    ) u_div_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v5_reg),
        .dividend  (32'd0 - frac5_reg),
        .divisor   (is_w),
        .in_side   ({frac5_reg, yl5_reg, yh5_reg, len5_reg}),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .out_side  (d1_side)
    );

    logic [31:0] d1_frac, d1_yl, d1_yh;
    logic [7:0]  d1_len;
    assign {d1_frac, d1_yl, d1_yh, d1_len} = d1_side;

    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg, v12_reg;
    logic [31:0] cnt7_reg, frac7_reg, yl7_reg, yh7_reg;
    logic [7:0]  len7_reg, len8_reg, len9_reg, len10_reg, len11_reg;
    logic [31:0] yl8_reg, yh8_reg, frac8_reg, cis8_reg;
    logic [31:0] yl9_reg, yh9_reg, frac9_reg, dy9_reg;
    logic [31:0] yl10_reg, yh10_reg, frac10_reg, dyis10_reg;
    logic [31:0] yl11_reg, yh11_reg, frac11_reg, end11_reg;
    logic [31:0] yl12_reg, yh12_reg, frac12_reg, a12_reg;
    logic        trim12_reg;
    logic [31:0] maxfrac11_w;

    assign maxfrac11_w = {8'd0, len11_reg, 16'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
        end else if (adv) begin
            v7_reg  <= d1_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cnt7_reg  <= d1_frac[31] ? asr16(d1_q + FRAC_MASK) : 32'd0;
            frac7_reg <= d1_frac;
            yl7_reg   <= d1_yl;
            yh7_reg   <= d1_yh;
            len7_reg  <= d1_len;

            yl8_reg   <= yl7_reg + cnt7_reg;
            cis8_reg  <= 32'(cnt7_reg * is_w);
            frac8_reg <= frac7_reg;
            yh8_reg   <= yh7_reg;
            len8_reg  <= len7_reg;

            frac9_reg <= frac8_reg + cis8_reg;
            dy9_reg   <= yh8_reg - yl8_reg;
            yl9_reg   <= yl8_reg;
            yh9_reg   <= yh8_reg;
            len9_reg  <= len8_reg;

            dyis10_reg <= 32'(dy9_reg * is_w);
            frac10_reg <= frac9_reg;
            yl10_reg   <= yl9_reg;
            yh10_reg   <= yh9_reg;
            len10_reg  <= len9_reg;

            end11_reg  <= frac10_reg + dyis10_reg;
            frac11_reg <= frac10_reg;
            yl11_reg   <= yl10_reg;
            yh11_reg   <= yh10_reg;
            len11_reg  <= len10_reg;

            trim12_reg <= !($signed(end11_reg) < $signed(maxfrac11_w));
            a12_reg    <= end11_reg - maxfrac11_w - 32'd1;
            frac12_reg <= frac11_reg;
            yl12_reg   <= yl11_reg;
            yh12_reg   <= yh11_reg;
        end
    end

    // bottom trim division
    logic                   d2_valid;
    logic [31:0]            d2_q;
    logic [DIV2_SIDE_W-1:0] d2_side;

    sprc_div #(
        .SIDE_W (DIV2_SIDE_W)
    ) u_div_bot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v12_reg),
        .dividend  (a12_reg),
        .divisor   (is_w),
        .in_side   ({frac12_reg, yl12_reg, yh12_reg, trim12_reg}),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .out_side  (d2_side)
    );

    logic [31:0] d2_frac, d2_yl, d2_yh;
    logic        d2_trim;
    assign {d2_frac, d2_yl, d2_yh, d2_trim} = d2_side;

    logic        v13_reg, v14_reg;
    logic [31:0] cnt13_reg, frac13_reg, yl13_reg, yh13_reg;
    logic        trim13_reg;
    logic [31:0] frac14_reg, yl14_reg, yh14_reg;

    logic [15:0] top_row_reg, bottom_row_reg;
    logic [31:0] texture_frac_reg;
    logic        draw_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v13_reg      <= 1'b0;
            v14_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v13_reg      <= d2_valid;
            v14_reg      <= v13_reg;
            m_tvalid_reg <= v14_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cnt13_reg  <= asr16(d2_q + FRAC_MASK);
            trim13_reg <= d2_trim;
            frac13_reg <= d2_frac;
            yl13_reg   <= d2_yl;
            yh13_reg   <= d2_yh;

            yh14_reg   <= trim13_reg ? (yh13_reg - cnt13_reg) : yh13_reg;
            yl14_reg   <= yl13_reg;
            frac14_reg <= frac13_reg;

            top_row_reg      <= yl14_reg[15:0];
            bottom_row_reg   <= yh14_reg[15:0];
            texture_frac_reg <= frac14_reg;
            draw_enable_reg  <= !yl14_reg[31]
                && ($signed(yh14_reg) < $signed({19'd0, view_height_reg}))
                && !($signed(yh14_reg) < $signed(yl14_reg));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, draw_enable_reg, texture_frac_reg, bottom_row_reg, top_row_reg};

    `include "sprite_post_clip_macros.svh"

    `SPC_ASSERT_NOW(a_ready_follows_output, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready disagrees with output stall")
    `SPC_ASSERT_NOW(a_draw_top_on_screen, m_tvalid && m_tdata[64], !m_tdata[15], "draw with negative top row")
    `SPC_ASSERT_NOW(a_draw_rows_ordered, m_tvalid && m_tdata[64], $signed(m_tdata[31:16]) >= $signed(m_tdata[15:0]), "draw with bottom above top")
    `SPC_ASSERT_NEXT(a_cfg_height_write, cfg_valid && cfg_index == CFG_VIEW_HEIGHT, view_height_reg == $past(cfg_data[12:0]), "view height write lost")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sprc_pkg::*;

    typedef struct packed {
        logic [15:0] top_row;
        logic [15:0] bottom_row;
        logic [31:0] texture_frac;
        logic        draw_enable;
    } post_clip_t;

    class post_scoreboard;
        logic [31:0] scale, spr_top, inv_scale, tex_mid, ctr_y, view_h;
        post_clip_t  pending[$];
        int          errors;

        function new();
            scale = 32'd65536; spr_top = 0; inv_scale = 32'd65535;
            tex_mid = 0; ctr_y = 32'd6553600; view_h = 32'd200; errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [31:0] v);
            case (idx)
                CFG_SPRITE_SCALE:  scale = {1'b0, v[30:0]};
                CFG_SPRITE_TOP:    spr_top = v;
                CFG_INVERSE_SCALE: inv_scale = v;
                CFG_TEXTURE_MID:   tex_mid = v;
                CFG_CENTER_Y:      ctr_y = v;
                CFG_VIEW_HEIGHT:   view_h = {19'd0, v[12:0]};
                default: ;
            endcase
        endfunction

        function logic [31:0] shr16(logic [31:0] v);
            return {{16{v[31]}}, v[31:16]};
        endfunction

        function logic [31:0] fixmul(logic [31:0] a, logic [31:0] b);
            longint p;
            p = longint'($signed(a)) * longint'($signed(b));
            return p[47:16];
        endfunction

        function logic [31:0] fixdiv(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb;
            longint q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            if ((ma >> 14) >= mb)
                return ((a ^ b) & 32'h8000_0000) != 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            q = (longint'($signed(a)) * 65536) / longint'($signed(b));
            return q[31:0];
        endfunction

        function post_clip_t clip_post(logic [47:0] d);
            logic [31:0] st, ln, cr, fr, top, yl, yh, frac, endf, maxf, cnt;
            post_clip_t r;
            st = {24'd0, d[7:0]};
            ln = {24'd0, d[15:8]};
            cr = {{18{d[29]}}, d[29:16]};
            fr = {19'd0, d[42:30]};
            top = spr_top + scale * st + 1;
            yl = shr16(top + FRAC_ONE);
            yh = shr16(top + scale * ln);
            if ($signed(yl) < $signed(cr + 32'd1)) yl = cr + 32'd1;
            if ($signed(fr - 32'd1) < $signed(yh)) yh = fr - 32'd1;
            frac = tex_mid - (st << 16) + yl * inv_scale - fixmul(ctr_y - FRAC_ONE, inv_scale);
            if (frac[31]) begin
                cnt = shr16(fixdiv(-frac, inv_scale) + FRAC_ONE - 32'd1);
                yl = yl + cnt;
                frac = frac + cnt * inv_scale;
            end
            endf = frac + (yh - yl) * inv_scale;
            maxf = ln << 16;
            if (!($signed(endf) < $signed(maxf))) begin
                cnt = shr16(fixdiv(endf - maxf - 32'd1, inv_scale) + FRAC_ONE - 32'd1);
                yh = yh - cnt;
            end
            r.top_row = yl[15:0];
            r.bottom_row = yh[15:0];
            r.texture_frac = frac;
            r.draw_enable = !yl[31] && (longint'($signed(yh)) < longint'(view_h))
                            && !($signed(yh) < $signed(yl));
            return r;
        endfunction

        function void note_post(logic [47:0] d);
            pending.push_back(clip_post(d));
        endfunction

        function void check_result(logic [71:0] m);
            post_clip_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", m);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (m[15:0] !== e.top_row) begin
                $error("top_row exp %h got %h", e.top_row, m[15:0]); errors++;
            end
            if (m[31:16] !== e.bottom_row) begin
                $error("bottom_row exp %h got %h", e.bottom_row, m[31:16]); errors++;
            end
            if (m[63:32] !== e.texture_frac) begin
                $error("texture_frac exp %h got %h", e.texture_frac, m[63:32]); errors++;
            end
            if (m[64] !== e.draw_enable) begin
                $error("draw_enable exp %b got %b", e.draw_enable, m[64]); errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    post_scoreboard sb = new();
    bit quiet = 0, hold_req = 0;
    int stall_left = 0;
    longint cycles = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    sprite_post_clip u_top (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_post(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!aresetn) begin
            m_tready <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else if (hold_req) begin
            hold_req = 0;
            m_tready <= 0;
            stall_left <= 400;
        end else if (quiet || r < 75) begin
            m_tready <= 1;
        end else begin
            m_tready <= 0;
            stall_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
    end

    task automatic cfg_write(cfg_index_t idx, logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic send_post(logic [7:0] st, logic [7:0] ln, logic [13:0] cr, logic [12:0] fr);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = quiet ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
        s_tvalid <= 1;
        s_tdata <= {5'd0, fr, cr, ln, st};
        do @(posedge aclk); while (!s_tready);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_posts(int n);
        logic [13:0] cr;
        logic [12:0] fr;
        repeat (n) begin
            cr = $urandom_range(0, 9) == 0 ? -14'sd1 : 14'($urandom_range(0, 4096));
            fr = 13'($urandom_range(0, 4097));
            if ($urandom_range(0, 3) != 0) begin
                cr = $urandom_range(0, 3) == 0 ? -14'sd1 : 14'($urandom_range(0, 300));
                fr = 13'($urandom_range(cr + 1, 4097));
            end
            send_post(8'($urandom), 8'($urandom), cr, fr);
        end
    endtask

    task automatic typical_config();
        logic [31:0] sc, cy, tm;
        sc = $urandom_range(32'h2000, 32'h8_0000);
        cy = $urandom_range(0, 4096) << 16;
        tm = $urandom_range(0, 400 << 16) - (200 << 16);
        cfg_write(CFG_SPRITE_SCALE, sc);
        cfg_write(CFG_INVERSE_SCALE, 32'hFFFF_FFFF / sc);
        cfg_write(CFG_CENTER_Y, cy);
        cfg_write(CFG_TEXTURE_MID, tm);
        cfg_write(CFG_SPRITE_TOP, cy - sb.fixmul(tm, sc) + $urandom_range(0, 32'h40000));
        cfg_write(CFG_VIEW_HEIGHT, $urandom_range(1, 4096));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // defaults: extremes of the post fields
        send_post(0, 0, -14'sd1, 0);
        send_post(255, 255, -14'sd1, 4097);
        send_post(0, 255, 0, 200);
        send_post(255, 0, 4096, 4097);
        send_post(10, 20, 50, 60);
        send_post(100, 50, 150, 4096);
        send_post(0, 1, 199, 200);
        send_post(8'hAA, 8'h55, 14'h1555, 13'h0AAA);
        send_post(8'h55, 8'hAA, 14'h0AAA, 13'h1555);
        drain();

        // negative fraction and bottom trim with the default scale
        cfg_write(CFG_TEXTURE_MID, -(32'd50 << 16));
        cfg_write(CFG_SPRITE_TOP, 32'd40 << 16);
        for (int i = 0; i < 6; i++) send_post(8'(i * 40), 8'(255 - i * 40), -14'sd1, 4097);
        drain();

        // saturating divides: zero and huge inverse scale, zero view height
        cfg_write(CFG_INVERSE_SCALE, 0);
        cfg_write(CFG_VIEW_HEIGHT, 0);
        send_post(3, 9, -14'sd1, 4097);
        send_post(200, 255, 10, 20);
        drain();
        cfg_write(CFG_SPRITE_SCALE, 32'h7FFF_FFFF);
        cfg_write(CFG_SPRITE_TOP, 32'h7FFF_FFFF);
        cfg_write(CFG_INVERSE_SCALE, 32'hFFFF_FFFF);
        cfg_write(CFG_TEXTURE_MID, 32'h7FFF_FFFF);
        cfg_write(CFG_CENTER_Y, 32'h7FFF_FFFF);
        cfg_write(CFG_VIEW_HEIGHT, 4096);
        random_posts(60);
        drain();
        cfg_write(CFG_SPRITE_SCALE, 1);
        cfg_write(CFG_SPRITE_TOP, 32'h8000_0000);
        cfg_write(CFG_INVERSE_SCALE, 1);
        cfg_write(CFG_TEXTURE_MID, 32'h8000_0000);
        cfg_write(CFG_CENTER_Y, 32'h8000_0000);
        cfg_write(CFG_VIEW_HEIGHT, 1);
        random_posts(60);
        drain();
        cfg_write(CFG_INVERSE_SCALE, 32'h8000_0000);
        cfg_write(CFG_VIEW_HEIGHT, 13'h1FFF);
        random_posts(40);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            typical_config();
            quiet = (ph == 2);
            if (ph == 4) hold_req = 1;
            random_posts(180);
            quiet = 0;
            drain();
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/sprc_pkg.sv
rtl/sprc_div.sv
rtl/sprite_post_clip.sv
tb/tb.sv
